FILE: rtl/handle_hash_bucket_unit_assert.svh
// ----------------------------------------------------------------------------
// Handle hash bucket unit assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HANDLE_HASH_BUCKET_UNIT_ASSERT_SVH
`define HANDLE_HASH_BUCKET_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define HHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define HHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HHB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/hhb_pkg.sv
// ----------------------------------------------------------------------------
// Handle hash bucket package
// Constants and word packing helper for the handle hash bucket unit.
// ----------------------------------------------------------------------------
package hhb_pkg;

	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned COUNT_W    = 3;
	localparam int unsigned TDATA_W    = 72;

	localparam logic [DATA_W-1:0] HASH_BIAS  = 32'd1999;
	localparam logic [DATA_W-1:0] TSIZE_RST  = 32'd1;

	typedef logic [DATA_W-1:0] word_t;

	// Pack a short final word big-endian: lowest-offset byte ends up highest.
	function automatic word_t pack_short(input word_t word, input logic [COUNT_W-1:0] count);
		word_t      acc;
		logic [7:0] b;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			b = (i < 4) ? word[8*(i & 3) +: 8] : 8'h00;
			if (i < int'(count)) begin
				acc = {acc[23:0], b};
			end
		end
		return acc;
	endfunction

	// Select the word that gets folded into the running sum.
	function automatic word_t prep_word(input word_t word, input logic [COUNT_W-1:0] count);
		return (int'(count) >= WORD_BYTES) ? word : pack_short(word, count);
	endfunction

endpackage

FILE: rtl/handle_hash_bucket_unit.sv
// ----------------------------------------------------------------------------
// Handle hash bucket unit
// Streams a file handle in 32-bit words and returns its hash bucket index.
// ----------------------------------------------------------------------------
// A handle arrives as a run of words, tuser marking the first and tlast the
// final one. The first word loads the seed; each word with bytes then updates
// sum = ((3*sum + 5*word + 1999) mod 2^32) mod table_size, and the bucket goes
// out on the final word. A word with zero valid bytes folds nothing in, so a
// lone empty first-and-last item returns the seed unreduced. A table_size of 0
// skips the reduction. A word with bytes passes from acceptance through the
// multiply and add steps and the radix-2 restoring remainder unit before the
// next word can be taken; with table_size 0 the remainder is skipped. A final
// word then passes the emit step to hand the bucket to the output register.
// A word with zero bytes returns to idle, or goes to the emit step when final.
// The output register holds the bucket until it is taken while the next
// handle already streams in; a new bucket waits only if the previous one has
// not been taken yet. Write table_size only while the unit is idle; the write
// channel is always ready.
// ----------------------------------------------------------------------------
`include "handle_hash_bucket_unit_assert.svh"

module handle_hash_bucket_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: table_size
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hhb_pkg::DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// s_tdata fields from bit 0: data_word[31:0], valid_bytes[34:32],
	// seed[66:35], zero fill[71:67]
	input  logic [hhb_pkg::TDATA_W-1:0]  s_tdata,
	// s_tuser fields from bit 0: first_word[0]
	input  logic                         s_tuser,
	input  logic                         s_tlast,
	// output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// m_tdata fields from bit 0: bucket[31:0]
	output logic [hhb_pkg::DATA_W-1:0]   m_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]           state_q;
	hhb_pkg::word_t       tsize_q;   // table_size register
	hhb_pkg::word_t       sum_q;     // running sum
	hhb_pkg::word_t       word_q;    // prepared word for this transaction
	hhb_pkg::word_t       dvd_q;     // value being reduced, shifts left
	hhb_pkg::word_t       rem_q;     // partial remainder
	logic [4:0]           cnt_q;     // remainder steps left after this one
	logic                 last_q;
	logic                 outv_q;
	hhb_pkg::word_t       out_q;

	// input fields
	hhb_pkg::word_t                  in_word;
	logic [hhb_pkg::COUNT_W-1:0]     in_count;
	hhb_pkg::word_t                  in_seed;

	assign in_word  = s_tdata[31:0];
	assign in_count = s_tdata[34:32];
	assign in_seed  = s_tdata[66:35];

	logic           in_acc;
	logic           out_free;
	hhb_pkg::word_t sum_in;
	hhb_pkg::word_t mul_val;
	hhb_pkg::word_t add_val;
	logic [32:0]    trial;
	logic           fits;
	hhb_pkg::word_t rem_nxt;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !outv_q || m_tready;
	assign m_tvalid  = outv_q;
	assign m_tdata   = out_q;

	assign sum_in  = s_tuser ? in_seed : sum_q;
	// 3*sum + bias, then + 5*word, both modulo 2^32
	assign mul_val = {sum_q[30:0], 1'b0} + sum_q + hhb_pkg::HASH_BIAS;
	assign add_val = dvd_q + {word_q[29:0], 2'b00} + word_q;

	// one restoring remainder step: shift in the next dividend bit, subtract if it fits
	assign trial   = {rem_q, dvd_q[31]};
	assign fits    = (trial >= {1'b0, tsize_q});
	assign rem_nxt = fits ? 32'(trial - {1'b0, tsize_q}) : trial[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tsize_q <= hhb_pkg::TSIZE_RST;
			sum_q   <= '0;
			last_q  <= 1'b0;
			outv_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tsize_q <= cfg_data;
			end
			// drop the output flag once the bucket is taken
			if (outv_q && m_tready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sum_q  <= sum_in;
						last_q <= s_tlast;
						if (in_count != '0) begin
							state_q <= ST_MUL;
						end else if (s_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					cnt_q <= 5'd31;
					if (tsize_q == '0) begin
						// no reduction: keep the sum modulo 2^32
						sum_q   <= add_val;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						sum_q   <= rem_nxt;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						outv_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					word_q <= hhb_pkg::prep_word(in_word, in_count);
				end
			end
			ST_MUL: begin
				dvd_q <= mul_val;
			end
			ST_ADD: begin
				dvd_q <= add_val;
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[30:0], 1'b0};
				rem_q <= rem_nxt;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	// the partial remainder always stays below the table size
	`HHB_ASSERT_IMP(a_rem_below_size, clk, arst_n, (state_q == ST_DIV), (rem_q < tsize_q), "partial remainder not below table_size")
	// a final transaction always leaves idle to produce its bucket
	`HHB_ASSERT_NXT(a_last_leaves_idle, clk, arst_n, (in_acc && s_tlast), (state_q != ST_IDLE), "final word did not start bucket delivery")
	// a new bucket only appears from the emit step
	`HHB_ASSERT_IMP(a_out_from_emit, clk, arst_n, $rose(outv_q), ($past(state_q) == ST_EMIT), "bucket raised outside the emit step")

endmodule
